// ===== src/stl_pkg.sv =====
`default_nettype none
package stl_pkg;

    localparam int INT_WIDTH = 32;
    localparam int QDEPTH    = 4;
    localparam int QAW       = $clog2(QDEPTH);

    localparam logic [4:0] K_TEXT   = 5'd0;
    localparam logic [4:0] K_ID     = 5'd1;
    localparam logic [4:0] K_STR    = 5'd2;
    localparam logic [4:0] K_INT    = 5'd3;
    localparam logic [4:0] K_BOOL   = 5'd4;
    localparam logic [4:0] K_TYPE   = 5'd5;
    localparam logic [4:0] K_IF     = 5'd6;
    localparam logic [4:0] K_ELSE   = 5'd7;
    localparam logic [4:0] K_LPAREN = 5'd8;
    localparam logic [4:0] K_RPAREN = 5'd9;
    localparam logic [4:0] K_LBRACE = 5'd10;
    localparam logic [4:0] K_RBRACE = 5'd11;
    localparam logic [4:0] K_COMMA  = 5'd12;
    localparam logic [4:0] K_SEMI   = 5'd13;
    localparam logic [4:0] K_COLON  = 5'd14;
    localparam logic [4:0] K_OP     = 5'd15;
    localparam logic [4:0] K_END    = 5'd16;
    localparam logic [4:0] K_ERROR  = 5'd17;

    localparam logic [3:0] OP_ADD  = 4'd0;
    localparam logic [3:0] OP_SUB  = 4'd1;
    localparam logic [3:0] OP_MUL  = 4'd2;
    localparam logic [3:0] OP_DIV  = 4'd3;
    localparam logic [3:0] OP_XOR  = 4'd4;
    localparam logic [3:0] OP_AND  = 4'd5;
    localparam logic [3:0] OP_OR   = 4'd6;
    localparam logic [3:0] OP_ASGN = 4'd7;
    localparam logic [3:0] OP_LAND = 4'd8;
    localparam logic [3:0] OP_LOR  = 4'd9;
    localparam logic [3:0] OP_EQ   = 4'd10;
    localparam logic [3:0] OP_NE   = 4'd11;

    localparam logic [1:0] ERR_NONE       = 2'd0;
    localparam logic [1:0] ERR_UNEXPECTED = 2'd1;
    localparam logic [1:0] ERR_OPEN_STR   = 2'd2;

    localparam logic [2:0] TY_NONE = 3'd0;

    localparam logic [2:0] KW_TRUE  = 3'd0;
    localparam logic [2:0] KW_FALSE = 3'd1;
    localparam logic [2:0] KW_IFW   = 3'd2;
    localparam logic [2:0] KW_ELSEW = 3'd3;
    localparam logic [2:0] KW_INTW  = 3'd4;
    localparam logic [2:0] KW_BOOLW = 3'd5;
    localparam logic [2:0] KW_STRW  = 3'd6;
    localparam logic [2:0] KW_VOIDW = 3'd7;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_DQ    = 8'h22;
    localparam logic [7:0] CH_SQ    = 8'h27;

    typedef struct packed {
        logic [7:0] byte_in;
        logic       end_mark;
    } in_word_t;

    typedef struct packed {
        logic [4:0]  kind;
        logic [7:0]  text_char;
        logic [31:0] int_value;
        logic        bool_value;
        logic [2:0]  type_code;
        logic [3:0]  op_code;
        logic [1:0]  error_code;
        logic        last_result;
    } out_word_t;

    typedef struct packed {
        logic      two;
        out_word_t first;
        out_word_t second;
    } q_entry_t;

    typedef struct packed {
        logic     empty;
        q_entry_t head;
    } q_status_t;

    typedef enum logic [7:0] {
        MODE_IDLE  = 8'b0000_0001,
        MODE_INT   = 8'b0000_0010,
        MODE_IDENT = 8'b0000_0100,
        MODE_STR   = 8'b0000_1000,
        MODE_BANG  = 8'b0001_0000,
        MODE_AMP   = 8'b0010_0000,
        MODE_BAR   = 8'b0100_0000,
        MODE_EQ    = 8'b1000_0000
    } mode_t;

    function automatic out_word_t make_res(input logic [4:0] kind,
                                           input logic [7:0] tc,
                                           input logic [31:0] iv,
                                           input logic bv,
                                           input logic [2:0] ty,
                                           input logic [3:0] op,
                                           input logic [1:0] err);
        out_word_t r;
        r.kind        = kind;
        r.text_char   = tc;
        r.int_value   = iv;
        r.bool_value  = bv;
        r.type_code   = ty;
        r.op_code     = op;
        r.error_code  = err;
        r.last_result = 1'b0;
        return r;
    endfunction

    function automatic logic [2:0] kw_len(input logic [2:0] k);
        logic [2:0] n;
        unique case (k)
            KW_TRUE:  n = 3'd4;
            KW_FALSE: n = 3'd5;
            KW_IFW:   n = 3'd2;
            KW_ELSEW: n = 3'd4;
            KW_INTW:  n = 3'd3;
            KW_BOOLW: n = 3'd4;
            KW_STRW:  n = 3'd6;
            default:  n = 3'd4;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] kw_char(input logic [2:0] k, input logic [2:0] p);
        logic [55:0] w;
        logic [7:0]  ch;
        unique case (k)
            KW_TRUE:  w = {"true", 24'h0};
            KW_FALSE: w = {"false", 16'h0};
            KW_IFW:   w = {"if", 40'h0};
            KW_ELSEW: w = {"else", 24'h0};
            KW_INTW:  w = {"int", 32'h0};
            KW_BOOLW: w = {"bool", 24'h0};
            KW_STRW:  w = {"string", 8'h0};
            default:  w = {"void", 24'h0};
        endcase
        if (p == 3'd7)
        begin
            ch = 8'h00;
        end
        else
        begin
            ch = w[8 * (3'd6 - p) +: 8];
        end
        return ch;
    endfunction

endpackage
`default_nettype wire

// ===== src/source_text_lexer_top.sv =====
`default_nettype none
// channel   signals                          word
// input     in_valid  in_stall  in_data      in_word_t  (byte_in, end_mark)
// output    out_valid out_stall out_data     out_word_t (one token or text char)
//
// one input word per cycle; the lexer state updates in the cycle it is taken
// a word that yields two tokens fills one queue entry and leaves as two output words, the
// four-entry queue between lexer and output absorbs that and output stalls
// input stalls only while the queue is full
// asynchronous active-low reset returns the lexer to idle and empties the queue
module source_text_lexer_top (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire stl_pkg::in_word_t in_data,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output stl_pkg::out_word_t     out_data
);
    import stl_pkg::*;

    logic      q_full;
    logic      push;
    logic      pop;
    q_entry_t  push_entry;
    q_status_t status;

    stl_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_data    (in_data),
        .q_full     (q_full),
        .in_stall   (in_stall),
        .push       (push),
        .push_entry (push_entry)
    );

    stl_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .full       (q_full),
        .status     (status)
    );

    stl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .status     (status),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (out_data)
    );

endmodule
`default_nettype wire

// ===== src/stl_front.sv =====
`default_nettype none
module stl_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    input  wire stl_pkg::in_word_t in_data,
    input  wire logic              q_full,
    output logic                   in_stall,
    output logic                   push,
    output stl_pkg::q_entry_t      push_entry
);
    import stl_pkg::*;

    mode_t                mode_reg,  mode_next;
    logic [INT_WIDTH-1:0] acc_reg,   acc_next;
    logic                 quote_reg, quote_next;
    logic                 bs_reg,    bs_next;
    logic [7:0]           hits_reg,  hits_next;
    logic [2:0]           len_reg,   len_next;

    logic                 accept;
    logic [7:0]           c;
    logic                 eom;
    logic                 is_dig, is_alpha, is_idc;
    logic [INT_WIDTH-1:0] acc_step;
    logic [7:0]           hits_cont, hits_start;
    logic [2:0]           len_cont;
    logic [7:0]           pair_ch;
    logic                 same;
    logic                 a_vld, b_vld, fall;
    out_word_t            a_res, b_res, close_res;
    logic [2:0]           hit_k;
    logic                 hit_any;

    assign c        = in_data.byte_in;
    assign eom      = in_data.end_mark;
    assign accept   = in_valid && !q_full;
    assign in_stall = q_full;

    assign is_dig   = (c >= "0") && (c <= "9");
    assign is_alpha = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z"));
    assign is_idc   = is_alpha || is_dig || (c == "_");

    assign acc_step = INT_WIDTH'({acc_reg, 3'b000}) + INT_WIDTH'({acc_reg, 1'b0})
                    + INT_WIDTH'(c[3:0]);
    assign len_cont = (len_reg == 3'd7) ? 3'd7 : len_reg + 3'd1;

    always_comb
    begin
        hits_cont  = hits_reg;
        hits_start = 8'hFF;
        for (int k = 0; k < 8; k++)
        begin
            if ((len_reg >= kw_len(3'(k))) || (kw_char(3'(k), len_reg) != c))
            begin
                hits_cont[k] = 1'b0;
            end
            if (kw_char(3'(k), 3'd0) != c)
            begin
                hits_start[k] = 1'b0;
            end
        end
    end

    // keyword lookup, lowest index wins
    always_comb
    begin
        hit_any = 1'b0;
        hit_k   = 3'd0;
        for (int k = 7; k >= 0; k--)
        begin
            if (hits_reg[k] && (len_reg == kw_len(3'(k))))
            begin
                hit_any = 1'b1;
                hit_k   = 3'(k);
            end
        end
        if (!hit_any)
        begin
            close_res = make_res(K_ID, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
        end
        else
        begin
            unique case (hit_k)
                KW_TRUE:
                    close_res = make_res(K_BOOL, 8'h0, 32'h0, 1'b1, TY_NONE, OP_ADD,
                                         ERR_NONE);
                KW_FALSE:
                    close_res = make_res(K_BOOL, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                         ERR_NONE);
                KW_IFW:
                    close_res = make_res(K_IF, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                         ERR_NONE);
                KW_ELSEW:
                    close_res = make_res(K_ELSE, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                         ERR_NONE);
                default:
                    close_res = make_res(K_TYPE, 8'h0, 32'h0, 1'b0, hit_k - 3'd3, OP_ADD,
                                         ERR_NONE);
            endcase
        end
    end

    always_comb
    begin
        unique case (mode_reg)
            MODE_AMP: pair_ch = "&";
            MODE_BAR: pair_ch = "|";
            default:  pair_ch = "=";
        endcase
        same = !eom && (c == pair_ch);
    end

    always_comb
    begin
        mode_next  = mode_reg;
        acc_next   = acc_reg;
        quote_next = quote_reg;
        bs_next    = bs_reg;
        hits_next  = hits_reg;
        len_next   = len_reg;
        a_vld      = 1'b0;
        a_res      = '0;
        b_vld      = 1'b0;
        b_res      = '0;
        fall       = 1'b1;

        unique case (mode_reg)
            MODE_INT:
            begin
                if (!eom && is_dig)
                begin
                    acc_next = acc_step;
                    fall     = 1'b0;
                end
                else
                begin
                    a_vld = 1'b1;
                    a_res = make_res(K_INT, 8'h0, 32'(acc_reg), 1'b0, TY_NONE, OP_ADD,
                                     ERR_NONE);
                end
            end
            MODE_IDENT:
            begin
                if (!eom && is_idc)
                begin
                    hits_next = hits_cont;
                    len_next  = len_cont;
                    a_vld     = 1'b1;
                    a_res     = make_res(K_TEXT, c, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
                    fall      = 1'b0;
                end
                else
                begin
                    a_vld = 1'b1;
                    a_res = close_res;
                end
            end
            MODE_STR:
            begin
                a_vld = 1'b1;
                if (eom)
                begin
                    a_res = make_res(K_ERROR, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                     ERR_OPEN_STR);
                end
                else if ((c == (quote_reg ? CH_SQ : CH_DQ)) && !bs_reg)
                begin
                    a_res     = make_res(K_STR, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
                    mode_next = MODE_IDLE;
                    fall      = 1'b0;
                end
                else
                begin
                    a_res   = make_res(K_TEXT, c, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
                    bs_next = (c == CH_BSL);
                    fall    = 1'b0;
                end
            end
            MODE_BANG:
            begin
                a_vld = 1'b1;
                if (!eom && (c == "="))
                begin
                    a_res     = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_NE, ERR_NONE);
                    mode_next = MODE_IDLE;
                    fall      = 1'b0;
                end
                else
                begin
                    a_res = make_res(K_ERROR, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                     ERR_UNEXPECTED);
                end
            end
            MODE_AMP, MODE_BAR, MODE_EQ:
            begin
                a_vld = 1'b1;
                unique case (mode_reg)
                    MODE_AMP:
                        a_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE,
                                         same ? OP_LAND : OP_AND, ERR_NONE);
                    MODE_BAR:
                        a_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE,
                                         same ? OP_LOR : OP_OR, ERR_NONE);
                    default:
                        a_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE,
                                         same ? OP_EQ : OP_ASGN, ERR_NONE);
                endcase
                if (same)
                begin
                    mode_next = MODE_IDLE;
                    fall      = 1'b0;
                end
            end
            default:
            begin
            end
        endcase

        if (fall)
        begin
            mode_next = MODE_IDLE;
            if (eom)
            begin
                b_vld = 1'b1;
                b_res = make_res(K_END, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
            end
            else
            begin
                priority if ((c == CH_SPACE) || (c == CH_LF) || (c == CH_CR))
                begin
                end
                else if (is_dig)
                begin
                    mode_next = MODE_INT;
                    acc_next  = INT_WIDTH'(c[3:0]);
                end
                else if (is_alpha || (c == "_"))
                begin
                    mode_next = MODE_IDENT;
                    hits_next = hits_start;
                    len_next  = 3'd1;
                    b_vld     = 1'b1;
                    b_res     = make_res(K_TEXT, c, 32'h0, 1'b0, TY_NONE, OP_ADD, ERR_NONE);
                end
                else if ((c == CH_DQ) || (c == CH_SQ))
                begin
                    mode_next  = MODE_STR;
                    quote_next = (c == CH_SQ);
                    bs_next    = 1'b0;
                end
                else if (c == "!")
                begin
                    mode_next = MODE_BANG;
                end
                else if (c == "&")
                begin
                    mode_next = MODE_AMP;
                end
                else if (c == "|")
                begin
                    mode_next = MODE_BAR;
                end
                else if (c == "=")
                begin
                    mode_next = MODE_EQ;
                end
                else
                begin
                    b_vld = 1'b1;
                    unique case (c)
                        "(": b_res = make_res(K_LPAREN, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        ")": b_res = make_res(K_RPAREN, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        "{": b_res = make_res(K_LBRACE, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        "}": b_res = make_res(K_RBRACE, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        ",": b_res = make_res(K_COMMA, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        ";": b_res = make_res(K_SEMI, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        ":": b_res = make_res(K_COLON, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        "+": b_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                              ERR_NONE);
                        "-": b_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_SUB,
                                              ERR_NONE);
                        "*": b_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_MUL,
                                              ERR_NONE);
                        "/": b_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_DIV,
                                              ERR_NONE);
                        "^": b_res = make_res(K_OP, 8'h0, 32'h0, 1'b0, TY_NONE, OP_XOR,
                                              ERR_NONE);
                        default:
                            b_res = make_res(K_ERROR, 8'h0, 32'h0, 1'b0, TY_NONE, OP_ADD,
                                             ERR_UNEXPECTED);
                    endcase
                end
            end
        end
    end

    // pack one or two results into one queue entry; push nothing when there are none
    always_comb
    begin
        push_entry        = '0;
        push              = accept && (a_vld || b_vld);
        push_entry.two    = a_vld && b_vld;
        push_entry.first  = a_vld ? a_res : b_res;
        push_entry.second = b_res;
        push_entry.first.last_result  = !(a_vld && b_vld);
        push_entry.second.last_result = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            acc_reg   <= '0;
            quote_reg <= 1'b0;
            bs_reg    <= 1'b0;
            hits_reg  <= 8'hFF;
            len_reg   <= 3'd0;
        end
        else if (accept)
        begin
            mode_reg  <= mode_next;
            acc_reg   <= acc_next;
            quote_reg <= quote_next;
            bs_reg    <= bs_next;
            hits_reg  <= hits_next;
            len_reg   <= len_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/stl_queue.sv =====
`default_nettype none
module stl_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire stl_pkg::q_entry_t push_entry,
    input  wire logic              pop,
    output logic                   full,
    output stl_pkg::q_status_t     status
);
    import stl_pkg::*;

    q_entry_t       mem_reg [QDEPTH];
    logic [QAW-1:0] wr_reg, wr_next;
    logic [QAW-1:0] rd_reg, rd_next;
    logic [QAW:0]   cnt_reg, cnt_next;
    logic           do_push, do_pop;

    assign full         = (cnt_reg == (QAW + 1)'(QDEPTH));
    assign status.empty = (cnt_reg == '0);
    assign status.head  = mem_reg[rd_reg];
    assign do_push      = push && !full;
    assign do_pop       = pop && !status.empty;

    always_comb
    begin
        wr_next  = do_push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = do_pop  ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + (QAW + 1)'(do_push) - (QAW + 1)'(do_pop);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/stl_back.sv =====
`default_nettype none
module stl_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire stl_pkg::q_status_t status,
    output logic                    pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output stl_pkg::out_word_t      out_data
);
    import stl_pkg::*;

    logic phase_reg, phase_next;
    logic taken;

    assign out_valid = !status.empty;
    assign out_data  = phase_reg ? status.head.second : status.head.first;
    assign taken     = out_valid && !out_stall;

    // second word of a pair goes out one word later
    always_comb
    begin
        pop        = 1'b0;
        phase_next = phase_reg;
        if (taken)
        begin
            if (status.head.two && !phase_reg)
            begin
                phase_next = 1'b1;
            end
            else
            begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule
`default_nettype wire

// ===== tb/source_text_lexer_top_test.sv =====
module source_text_lexer_top_test;
    import stl_pkg::*;

    localparam int QUIET_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 750;

    localparam logic [2:0] TY_INT    = 3'd1;
    localparam logic [2:0] TY_BOOL   = 3'd2;
    localparam logic [2:0] TY_STRING = 3'd3;
    localparam logic [2:0] TY_VOID   = 3'd4;

    typedef struct packed {
        logic [7:0] ch;
        logic       fin;
        logic [1:0] typed;
        logic [4:0] k0;
        logic [1:0] e0;
        logic [4:0] k1;
        logic [1:0] e1;
    } plan_row_t;

    logic      clk;
    logic      rst_n;
    logic      in_valid  = 1'b0;
    logic      in_stall;
    in_word_t  in_data   = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    out_word_t out_data;

    source_text_lexer_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    // typed rows carry their tokens; the rest go through the predictor
    plan_row_t directed_rows [0:24] = '{
        '{8'hFF,    1'b1, 2'd1, K_END,   ERR_NONE,       K_TEXT, ERR_NONE},
        '{8'h00,    1'b0, 2'd1, K_ERROR, ERR_UNEXPECTED, K_TEXT, ERR_NONE},
        '{8'hFF,    1'b0, 2'd1, K_ERROR, ERR_UNEXPECTED, K_TEXT, ERR_NONE},
        '{"!",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{8'h00,    1'b1, 2'd2, K_ERROR, ERR_UNEXPECTED, K_END,  ERR_NONE},
        '{CH_SQ,    1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{8'h55,    1'b1, 2'd2, K_ERROR, ERR_OPEN_STR,   K_END,  ERR_NONE},
        '{"i",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"f",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"=",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"=",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"!",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"=",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"&",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"&",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"|",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"x",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{CH_SPACE, 1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{CH_DQ,    1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{CH_BSL,   1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{CH_DQ,    1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{CH_DQ,    1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{"0",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{";",      1'b0, 2'd0, K_TEXT,  ERR_NONE,       K_TEXT, ERR_NONE},
        '{8'hAA,    1'b1, 2'd1, K_END,   ERR_NONE,       K_TEXT, ERR_NONE}
    };

    string keyword_text [0:7] = '{"true", "false", "if", "else", "int", "bool", "string", "void"};
    string id_head = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_";
    string id_tail = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_0123456789";

    plan_row_t feed [$];
    out_word_t step_res [$];
    out_word_t tokens_due [$];

    mode_t                 lx_mode   = MODE_IDLE;
    logic [INT_WIDTH-1:0]  num_acc   = '0;
    logic                  sq_string = 1'b0;
    logic                  escaped   = 1'b0;
    logic [7:0]            kw_live   = '1;
    logic [2:0]            id_len    = '0;

    int          random_words   = 0;
    int          words_in       = 0;
    int          end_marks      = 0;
    int          tokens_checked = 0;
    int          mismatches     = 0;
    int          quiet_cycles   = 0;
    int          stall_left     = 0;
    logic [17:0] kinds_seen     = '0;
    logic [15:0] cycle_cnt      = '0;
    logic        calm;

    assign calm = (cycle_cnt[9:8] == 2'b00);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_alpha(input logic [7:0] c);
        return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    endfunction

    function automatic out_word_t make_tok(input logic [4:0] kind, input logic [31:0] detail);
        out_word_t t;
        t = '0;
        t.kind = kind;
        case (kind)
            K_TEXT:  t.text_char  = detail[7:0];
            K_INT:   t.int_value  = detail;
            K_BOOL:  t.bool_value = detail[0];
            K_TYPE:  t.type_code  = detail[2:0];
            K_OP:    t.op_code    = detail[3:0];
            K_ERROR: t.error_code = detail[1:0];
            default: ;
        endcase
        return t;
    endfunction

    task automatic emit_tok(input logic [4:0] kind, input logic [31:0] detail);
        if (step_res.size() < 2)
            step_res.push_back(make_tok(kind, detail));
    endtask

    task automatic take_ident_char(input logic [7:0] c);
        for (int k = 0; k < 8; k++)
            if (id_len >= keyword_text[k].len() || keyword_text[k][id_len] != c)
                kw_live[k] = 1'b0;
        if (id_len != 3'd7)
            id_len++;
        emit_tok(K_TEXT, c);
    endtask

    task automatic close_ident();
        int hit;
        hit = -1;
        for (int k = 7; k >= 0; k--)
            if (kw_live[k] && id_len == keyword_text[k].len())
                hit = k;
        if (hit < 0)
            emit_tok(K_ID, 0);
        else
            case (hit[2:0])
                KW_TRUE:  emit_tok(K_BOOL, 1);
                KW_FALSE: emit_tok(K_BOOL, 0);
                KW_IFW:   emit_tok(K_IF, 0);
                KW_ELSEW: emit_tok(K_ELSE, 0);
                KW_INTW:  emit_tok(K_TYPE, TY_INT);
                KW_BOOLW: emit_tok(K_TYPE, TY_BOOL);
                KW_STRW:  emit_tok(K_TYPE, TY_STRING);
                default:  emit_tok(K_TYPE, TY_VOID);
            endcase
    endtask

    task automatic start_token(input logic [7:0] c);
        lx_mode = MODE_IDLE;
        if (is_digit(c))
        begin
            lx_mode = MODE_INT;
            num_acc = '0;
            num_acc[3:0] = c[3:0];
        end
        else if (is_alpha(c) || c == "_")
        begin
            lx_mode = MODE_IDENT;
            kw_live = '1;
            id_len  = '0;
            take_ident_char(c);
        end
        else if (c == CH_DQ || c == CH_SQ)
        begin
            lx_mode   = MODE_STR;
            sq_string = (c == CH_SQ);
            escaped   = 1'b0;
        end
        else
            case (c)
                CH_SPACE, CH_LF, CH_CR: ;
                "(": emit_tok(K_LPAREN, 0);
                ")": emit_tok(K_RPAREN, 0);
                "{": emit_tok(K_LBRACE, 0);
                "}": emit_tok(K_RBRACE, 0);
                ",": emit_tok(K_COMMA, 0);
                ";": emit_tok(K_SEMI, 0);
                ":": emit_tok(K_COLON, 0);
                "+": emit_tok(K_OP, OP_ADD);
                "-": emit_tok(K_OP, OP_SUB);
                "*": emit_tok(K_OP, OP_MUL);
                "/": emit_tok(K_OP, OP_DIV);
                "^": emit_tok(K_OP, OP_XOR);
                "!": lx_mode = MODE_BANG;
                "&": lx_mode = MODE_AMP;
                "|": lx_mode = MODE_BAR;
                "=": lx_mode = MODE_EQ;
                default: emit_tok(K_ERROR, ERR_UNEXPECTED);
            endcase
    endtask

    task automatic lex_word(input logic [7:0] c, input logic fin);
        logic       restart;
        logic       twin;
        logic [3:0] op;
        out_word_t  tail;
        step_res.delete();
        restart = 1'b1;
        case (lx_mode)
            MODE_INT:
                if (!fin && is_digit(c))
                begin
                    num_acc = num_acc * 10 + c[3:0];
                    restart = 1'b0;
                end
                else
                    emit_tok(K_INT, num_acc);
            MODE_IDENT:
                if (!fin && (is_alpha(c) || is_digit(c) || c == "_"))
                begin
                    take_ident_char(c);
                    restart = 1'b0;
                end
                else
                    close_ident();
            MODE_STR:
                if (fin)
                    emit_tok(K_ERROR, ERR_OPEN_STR);
                else
                begin
                    restart = 1'b0;
                    if (c == (sq_string ? CH_SQ : CH_DQ) && !escaped)
                    begin
                        emit_tok(K_STR, 0);
                        lx_mode = MODE_IDLE;
                    end
                    else
                    begin
                        emit_tok(K_TEXT, c);
                        escaped = (c == CH_BSL);
                    end
                end
            MODE_BANG:
            begin
                lx_mode = MODE_IDLE;
                if (!fin && c == "=")
                begin
                    emit_tok(K_OP, OP_NE);
                    restart = 1'b0;
                end
                else
                    emit_tok(K_ERROR, ERR_UNEXPECTED);
            end
            MODE_AMP, MODE_BAR, MODE_EQ:
            begin
                twin = !fin && c == (lx_mode == MODE_AMP ? "&" : lx_mode == MODE_BAR ? "|" : "=");
                case (lx_mode)
                    MODE_AMP: op = twin ? OP_LAND : OP_AND;
                    MODE_BAR: op = twin ? OP_LOR : OP_OR;
                    default:  op = twin ? OP_EQ : OP_ASGN;
                endcase
                lx_mode = MODE_IDLE;
                emit_tok(K_OP, op);
                restart = !twin;
            end
            default: ;
        endcase
        if (restart)
        begin
            lx_mode = MODE_IDLE;
            if (fin)
                emit_tok(K_END, 0);
            else
                start_token(c);
        end
        if (step_res.size() != 0)
        begin
            tail = step_res.pop_back();
            tail.last_result = 1'b1;
            step_res.push_back(tail);
        end
    endtask

    function automatic logic [7:0] any_of(input string pool);
        return pool[$urandom_range(0, pool.len() - 1)];
    endfunction

    task automatic feed_char(input logic [7:0] c);
        plan_row_t r;
        r = '0;
        r.ch = c;
        feed.push_back(r);
        random_words++;
    endtask

    task automatic cmp_field(input string name, input logic [31:0] want, input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 16'd1;
        if (stall_left != 0)
        begin
            out_stall <= 1'b1;
            stall_left--;
        end
        else
        begin
            out_stall <= 1'b0;
            stall_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin : watch_ports
        plan_row_t row;
        out_word_t want;
        if (rst_n === 1'b1)
        begin
            quiet_cycles++;
            if (in_valid && !in_stall)
            begin
                quiet_cycles = 0;
                row = feed[words_in];
                words_in++;
                if (row.fin)
                    end_marks++;
                lex_word(row.ch, row.fin);
                if (row.typed != 2'd0)
                begin
                    step_res.delete();
                    want = make_tok(row.k0, row.e0);
                    want.last_result = (row.typed == 2'd1);
                    step_res.push_back(want);
                    if (row.typed == 2'd2)
                    begin
                        want = make_tok(row.k1, row.e1);
                        want.last_result = 1'b1;
                        step_res.push_back(want);
                    end
                end
                foreach (step_res[i])
                    tokens_due.push_back(step_res[i]);
            end
            if (out_valid && !out_stall)
            begin
                quiet_cycles = 0;
                if (out_data.kind <= K_ERROR)
                    kinds_seen[out_data.kind] = 1'b1;
                if (tokens_due.size() == 0)
                begin
                    $display("%0t: token kind %0d arrived with none expected",
                             $time, out_data.kind);
                    mismatches++;
                end
                else
                begin
                    want = tokens_due.pop_front();
                    cmp_field("kind", want.kind, out_data.kind);
                    cmp_field("text_char", want.text_char, out_data.text_char);
                    cmp_field("int_value", want.int_value, out_data.int_value);
                    cmp_field("bool_value", want.bool_value, out_data.bool_value);
                    cmp_field("type_code", want.type_code, out_data.type_code);
                    cmp_field("op_code", want.op_code, out_data.op_code);
                    cmp_field("error_code", want.error_code, out_data.error_code);
                    cmp_field("last_result", want.last_result, out_data.last_result);
                    tokens_checked++;
                end
            end
        end
    end

    initial
    begin
        wait (rst_n === 1'b1);
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge clk);
        $display("%0t: no word moved for %0d cycles, %0d tokens still due",
                 $time, QUIET_LIMIT, tokens_due.size());
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin : stimulus
        plan_row_t  row;
        string      kw;
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        int         gap;
        foreach (directed_rows[i])
            feed.push_back(directed_rows[i]);
        while (random_words < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 9))
                0, 1:
                begin
                    kw = keyword_text[$urandom_range(0, 7)];
                    n = kw.len();
                    if ($urandom_range(0, 9) == 0)
                        n = $urandom_range(1, n);
                    for (int i = 0; i < n; i++)
                        feed_char(kw[i]);
                    if ($urandom_range(0, 4) == 0)
                        feed_char(any_of(id_tail));
                end
                2:
                begin
                    n = $urandom_range(1, 10);
                    feed_char(any_of(id_head));
                    repeat (n - 1) feed_char(any_of(id_tail));
                end
                3:
                begin
                    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 14) : $urandom_range(1, 4);
                    repeat (n) feed_char(any_of("0123456789"));
                end
                4, 5:
                begin
                    q = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                    feed_char(q);
                    n = $urandom_range(0, 8);
                    repeat (n)
                    begin
                        case ($urandom_range(0, 9))
                            0:       c = CH_BSL;
                            1:       c = $urandom_range(0, 1) ? CH_DQ : CH_SQ;
                            2:       c = 8'($urandom_range(0, 255));
                            default: c = 8'($urandom_range(32, 126));
                        endcase
                        feed_char(c);
                    end
                    if ($urandom_range(0, 9) != 0)
                        feed_char(q);
                end
                6:
                    feed_char(any_of("+-*/^&|=!(){},;:"));
                7:
                begin
                    c = any_of("=!&|");
                    feed_char(c);
                    feed_char(c == "!" ? "=" : c);
                end
                8:
                    if ($urandom_range(0, 2) == 0)
                    begin
                        row = '0;
                        row.fin = 1'b1;
                        row.ch = 8'($urandom_range(0, 255));
                        feed.push_back(row);
                        random_words++;
                    end
                    else
                        feed_char(8'($urandom_range(0, 255)));
                default:
                begin
                    feed_char("!");
                    feed_char(8'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 1) == 0)
                case ($urandom_range(0, 2))
                    0:       feed_char(CH_SPACE);
                    1:       feed_char(CH_LF);
                    default: feed_char(CH_CR);
                endcase
        end

        wait (rst_n === 1'b1);
        @(posedge clk);
        foreach (feed[i])
        begin
            gap = pick_gap();
            if (gap != 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= '{byte_in: feed[i].ch, end_mark: feed[i].fin};
            @(posedge clk);
            while (in_stall !== 1'b0)
                @(posedge clk);
        end
        in_valid <= 1'b0;
        @(posedge clk);
        while (tokens_due.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);

        $display("lexed %0d words (%0d end marks), checked %0d tokens, %0d mismatches",
                 words_in, end_marks, tokens_checked, mismatches);
        $display("token kinds seen at the output: %0d of 18", $countones(kinds_seen));
        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
